FILE: src/bfs_pkg.sv
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared types and constants of the bit field store.
// ----------------------------------------------------------------------------
package bfs_pkg;

  localparam int BFS_WORD_COUNT_DEF = 1024;
  localparam int BFS_DATA_W         = 32;
  localparam int BFS_BIT_W          = 15;
  localparam int BFS_CNT_W          = 6;
  localparam int BFS_OFF_W          = 5;
  localparam int BFS_IDX_W          = BFS_BIT_W - BFS_OFF_W;
  localparam int BFS_RECIP_SH       = 20;

  localparam logic BFS_ACT_READ  = 1'b0;
  localparam logic BFS_ACT_WRITE = 1'b1;

  typedef struct packed {
    logic                  action;
    logic [BFS_OFF_W-1:0]  offset;
    logic [BFS_CNT_W-1:0]  count;
    logic [BFS_DATA_W-1:0] value;
  } bfs_op_t;

endpackage

FILE: src/bfs_front.sv
// ----------------------------------------------------------------------------
// bfs_front
// Accepts transactions, clamps the field width and reduces the word index
// modulo the store depth in a two-stage reciprocal pipeline.
// ----------------------------------------------------------------------------
module bfs_front
  import bfs_pkg::*;
#(
  parameter int WORD_COUNT = BFS_WORD_COUNT_DEF,
  parameter int AW         = $clog2(WORD_COUNT)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [BFS_BIT_W-1:0]  in_bit_start,
  input  logic [BFS_CNT_W-1:0]  in_bit_count,
  input  logic [BFS_DATA_W-1:0] in_write_value,
  output logic                  push_valid,
  input  logic                  push_ready,
  output bfs_op_t               push_op,
  output logic [AW-1:0]         push_idx
);

  localparam logic [BFS_RECIP_SH-1:0] RECIP =
    BFS_RECIP_SH'((2**BFS_RECIP_SH + WORD_COUNT - 1) / WORD_COUNT);
  localparam logic [16:0] WCONST = 17'(WORD_COUNT);

  logic                   s1_v_r;
  bfs_op_t                s1_op_r;
  logic [BFS_IDX_W-1:0]   s1_idx_r;
  logic                   s2_v_r;
  bfs_op_t                s2_op_r;
  logic [BFS_IDX_W-1:0]   s2_idx_r;
  logic [BFS_IDX_W-1:0]   s2_q_r;

  logic                   s2_adv;
  logic                   s1_adv;
  logic [BFS_CNT_W-1:0]   cnt_sat;
  logic [BFS_IDX_W+BFS_RECIP_SH-1:0] prod1;
  logic [BFS_IDX_W+16:0]  prod2;
  logic [BFS_IDX_W-1:0]   rem;

  assign s2_adv   = !s2_v_r || push_ready;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_ready = s1_adv;

  assign cnt_sat = (in_bit_count > BFS_CNT_W'(BFS_DATA_W)) ? BFS_CNT_W'(BFS_DATA_W)
                                                           : in_bit_count;

  assign prod1 = s1_idx_r * RECIP;
  assign prod2 = s2_q_r * WCONST;
  assign rem   = s2_idx_r - prod2[BFS_IDX_W-1:0];

  assign push_valid = s2_v_r;
  assign push_op    = s2_op_r;
  assign push_idx   = AW'(rem);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= in_valid;
        if (in_valid) begin
          s1_op_r.action <= in_action;
          s1_op_r.offset <= in_bit_start[BFS_OFF_W-1:0];
          s1_op_r.count  <= cnt_sat;
          s1_op_r.value  <= in_write_value;
          s1_idx_r       <= in_bit_start[BFS_BIT_W-1:BFS_OFF_W];
        end
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
        if (s1_v_r) begin
          s2_op_r  <= s1_op_r;
          s2_idx_r <= s1_idx_r;
          s2_q_r   <= prod1[BFS_IDX_W+BFS_RECIP_SH-1:BFS_RECIP_SH];
        end
      end
    end
  end

endmodule

FILE: src/bfs_queue.sv
// ----------------------------------------------------------------------------
// bfs_queue
// Two-entry queue between the front and the back part.
// ----------------------------------------------------------------------------
module bfs_queue
  import bfs_pkg::*;
#(
  parameter int AW = $clog2(BFS_WORD_COUNT_DEF)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  bfs_op_t       push_op,
  input  logic [AW-1:0] push_idx,
  output logic          pop_valid,
  input  logic          pop_ready,
  output bfs_op_t       pop_op,
  output logic [AW-1:0] pop_idx
);

  bfs_op_t       ent_op_r  [2];
  logic [AW-1:0] ent_idx_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_op     = ent_op_r[rd_ptr_r];
  assign pop_idx    = ent_idx_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        ent_op_r[wr_ptr_r]  <= push_op;
        ent_idx_r[wr_ptr_r] <= push_idx;
        wr_ptr_r            <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

FILE: src/bfs_back.sv
// ----------------------------------------------------------------------------
// bfs_back
// Word memory and sequencer: reads the two words of a field, then returns
// the field or, unless the field is zero bits wide, writes both words back.
// ----------------------------------------------------------------------------
module bfs_back
  import bfs_pkg::*;
#(
  parameter int WORD_COUNT = BFS_WORD_COUNT_DEF,
  parameter int AW         = $clog2(WORD_COUNT)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  bfs_op_t               q_op,
  input  logic [AW-1:0]         q_idx,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BFS_DATA_W-1:0] out_read_value
);

  typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_WR2} state_t;

  logic [BFS_DATA_W-1:0] mem [WORD_COUNT];

  state_t                state_r;
  bfs_op_t               cur_op_r;
  logic [AW-1:0]         first_r;
  logic [AW-1:0]         second_r;
  logic [BFS_DATA_W-1:0] rd0_r;
  logic [BFS_DATA_W-1:0] rd1_r;
  logic [BFS_DATA_W-1:0] lo_r;
  logic                  out_valid_r;
  logic [BFS_DATA_W-1:0] out_data_r;

  logic [AW:0]           inc;
  logic [AW-1:0]         sec;
  logic                  rd_en;
  logic                  out_load;
  logic [63:0]           window;
  logic [63:0]           win_shl;
  logic [BFS_DATA_W-1:0] fmask;
  logic [5:0]            rsh;
  logic [6:0]            wsh;
  logic [63:0]           placed;
  logic [63:0]           new_win;
  logic [BFS_DATA_W-1:0] rd_field;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [BFS_DATA_W-1:0] mem_wdata;

  assign inc   = {1'b0, q_idx} + (AW+1)'(1);
  assign sec   = (q_idx == AW'(WORD_COUNT - 1)) ? '0 : inc[AW-1:0];
  assign rd_en = (state_r == ST_IDLE) && q_valid;

  assign out_load = (state_r == ST_RD) && (cur_op_r.action == BFS_ACT_READ)
                    && (!out_valid_r || out_ready);

  assign q_ready        = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_read_value = out_data_r;

  always_comb begin
    window  = {rd0_r, rd1_r};
    win_shl = window << cur_op_r.offset;
    fmask   = (cur_op_r.count >= BFS_CNT_W'(BFS_DATA_W)) ? '1
            : ((BFS_DATA_W'(1) << cur_op_r.count) - BFS_DATA_W'(1));
    rsh     = 6'd32 - cur_op_r.count;
    wsh     = 7'd64 - {2'b00, cur_op_r.offset} - {1'b0, cur_op_r.count};
    placed  = {32'b0, fmask} << wsh;
    new_win = (window & ~placed) | ({32'b0, cur_op_r.value & fmask} << wsh);
    if (cur_op_r.count == '0) begin
      rd_field = '0;
    end else begin
      rd_field = win_shl[63:32] >> rsh;
    end
  end

  assign mem_we    = ((state_r == ST_RD) && (cur_op_r.action == BFS_ACT_WRITE)
                      && (cur_op_r.count != '0)) || (state_r == ST_WR2);
  assign mem_waddr = (state_r == ST_WR2) ? second_r : first_r;
  assign mem_wdata = (state_r == ST_WR2) ? lo_r : new_win[63:32];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd0_r <= mem[q_idx];
      rd1_r <= mem[sec];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= rd_field;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            cur_op_r <= q_op;
            first_r  <= q_idx;
            second_r <= sec;
            state_r  <= ST_RD;
          end
        end
        ST_RD: begin
          if (cur_op_r.action == BFS_ACT_READ) begin
            if (out_load) begin
              state_r <= ST_IDLE;
            end
          end else if (cur_op_r.count == '0) begin
            state_r <= ST_IDLE;
          end else begin
            lo_r    <= new_win[31:0];
            state_r <= ST_WR2;
          end
        end
        ST_WR2: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/bit_field_store_unit.sv
// ----------------------------------------------------------------------------
// bit_field_store_unit
// Bit-addressed store of 32-bit words with MSB-first field read and write.
// ----------------------------------------------------------------------------
// Fields of 1 to 32 bits are read or written at any bit address; bit 0 is the
// MSB of word 0 and a field may span two words, the second wrapping to word 0
// past the last word. Counts above 32 act as 32; a write of zero bits does
// nothing and a read of zero bits returns 0. Memory contents are undefined
// until written; there is no clearing pass. A transaction passes the front
// pipeline (word index modulo WORD_COUNT) and the queue; in the back part a
// read passes the IDLE and RD states and a write IDLE, RD and WR2, set by the
// single write port of the word memory (one read of both words, then one
// write per word). The back part takes a new transaction only in IDLE.
// ----------------------------------------------------------------------------
module bit_field_store_unit
  import bfs_pkg::*;
#(
  parameter int WORD_COUNT = BFS_WORD_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [BFS_BIT_W-1:0]  in_bit_start,
  input  logic [BFS_CNT_W-1:0]  in_bit_count,
  input  logic [BFS_DATA_W-1:0] in_write_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BFS_DATA_W-1:0] out_read_value
);

  localparam int AW = $clog2(WORD_COUNT);

  logic          f_valid;
  logic          f_ready;
  bfs_op_t       f_op;
  logic [AW-1:0] f_idx;
  logic          b_valid;
  logic          b_ready;
  bfs_op_t       b_op;
  logic [AW-1:0] b_idx;

  bfs_front #(
    .WORD_COUNT(WORD_COUNT),
    .AW        (AW)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_bit_start  (in_bit_start),
    .in_bit_count  (in_bit_count),
    .in_write_value(in_write_value),
    .push_valid    (f_valid),
    .push_ready    (f_ready),
    .push_op       (f_op),
    .push_idx      (f_idx)
  );

  bfs_queue #(
    .AW(AW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_op   (f_op),
    .push_idx  (f_idx),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .pop_op    (b_op),
    .pop_idx   (b_idx)
  );

  bfs_back #(
    .WORD_COUNT(WORD_COUNT),
    .AW        (AW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (b_valid),
    .q_ready       (b_ready),
    .q_op          (b_op),
    .q_idx         (b_idx),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_value(out_read_value)
  );

endmodule
